// ===== hdl/first_fit_free_list_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Simulation builds get checked properties; synthesis builds get empty bodies.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property clocked on clk_i, disabled while rst_ni is low.
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Property clocked on clk_i that also holds during reset.
`define FFA_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FFA_ASSERT(lbl, prop, msg)
`define FFA_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// ===== hdl/ffa_pkg.sv =====
// Shared constants, payload types and header-store port types for the allocator.
// No dependencies; every module file imports this package.
package ffa_pkg;

  // Arena geometry
  localparam int unsigned ARENA_UNITS = 4096;
  localparam int unsigned GROW_UNITS  = 1024;
  localparam int unsigned UNIT_BYTES  = 16;
  localparam int unsigned DEPTH       = ARENA_UNITS + 1;

  // Field widths
  localparam int unsigned AW   = 13;
  localparam int unsigned SW   = 13;
  localparam int unsigned NBW  = 16;
  localparam int unsigned MIDX = $clog2(DEPTH);

  // Walk bounds and their counter widths
  localparam int unsigned WALK_MAX = 2 * DEPTH + 8;
  localparam int unsigned LINK_MAX = DEPTH + 2;
  localparam int unsigned GW       = $clog2(WALK_MAX + 2);
  localparam int unsigned LGW      = $clog2(LINK_MAX + 2);

  typedef logic [AW-1:0] addr_t;
  typedef logic [SW-1:0] size_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_DONE  = 1'b0,
    ST_NOMEM = 1'b1
  } status_e;

  typedef struct packed {
    logic             cmd;
    logic [NBW-1:0]   nbytes;
    addr_t            block_addr;
  } ffa_req_t;

  typedef struct packed {
    logic  status;
    addr_t user_addr;
  } ffa_rsp_t;

  // Header store access: one read address, one write address for both arrays
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    addr_t wr_addr;
    logic  wr_size_en;
    size_t wr_size;
    logic  wr_next_en;
    addr_t wr_next;
  } hdr_req_t;

  typedef struct packed {
    size_t rd_size;
    addr_t rd_next;
  } hdr_rsp_t;

endpackage

// ===== hdl/ffa_hdr_store.sv =====
// Header store: block size and next-pointer arrays with registered reads.
// Depends on ffa_pkg; header 0 reads as zero until first written.
`include "first_fit_free_list_allocator_macros.svh"

module ffa_hdr_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffa_pkg::hdr_req_t req_i,
  output ffa_pkg::hdr_rsp_t rsp_o
);
  import ffa_pkg::*;

  size_t size_mem [DEPTH];
  addr_t next_mem [DEPTH];

  size_t size_rd_q;
  addr_t next_rd_q;
  logic  size0_vld_q;
  logic  next0_vld_q;
  logic  size_keep_q;
  logic  next_keep_q;
  logic  rd_in_range;
  logic  wr_in_range;

  assign rd_in_range = (req_i.rd_addr <= addr_t'(ARENA_UNITS));
  assign wr_in_range = (req_i.wr_addr <= addr_t'(ARENA_UNITS));

  // Write and read the arrays; drop accesses beyond the arena
  always_ff @(posedge clk_i) begin
    if (req_i.wr_size_en && wr_in_range) begin
      size_mem[req_i.wr_addr[MIDX-1:0]] <= req_i.wr_size;
    end
    if (req_i.wr_next_en && wr_in_range) begin
      next_mem[req_i.wr_addr[MIDX-1:0]] <= req_i.wr_next;
    end
    if (req_i.rd_en && rd_in_range) begin
      size_rd_q <= size_mem[req_i.rd_addr[MIDX-1:0]];
      next_rd_q <= next_mem[req_i.rd_addr[MIDX-1:0]];
    end
  end

  // Track the base header and mask reads that must return zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size0_vld_q <= 1'b0;
      next0_vld_q <= 1'b0;
      size_keep_q <= 1'b0;
      next_keep_q <= 1'b0;
    end else begin
      if (req_i.wr_size_en && (req_i.wr_addr == '0)) begin
        size0_vld_q <= 1'b1;
      end
      if (req_i.wr_next_en && (req_i.wr_addr == '0)) begin
        next0_vld_q <= 1'b1;
      end
      if (req_i.rd_en) begin
        size_keep_q <= rd_in_range && ((req_i.rd_addr != '0) || size0_vld_q);
        next_keep_q <= rd_in_range && ((req_i.rd_addr != '0) || next0_vld_q);
      end
    end
  end

  assign rsp_o.rd_size = size_keep_q ? size_rd_q : '0;
  assign rsp_o.rd_next = next_keep_q ? next_rd_q : '0;

  // The sequencer never reads an entry in the cycle it writes it
  `FFA_ASSERT_NORST(a_no_rw_collide, (req_i.rd_en && (req_i.wr_size_en || req_i.wr_next_en)) |-> (req_i.rd_addr != req_i.wr_addr), "header read collides with write")

endmodule

// ===== hdl/ffa_ctrl.sv =====
// Request sequencer: walks the free list, splits, grows the break and coalesces.
// Depends on ffa_pkg; drives the header store through one request struct.
`include "first_fit_free_list_allocator_macros.svh"

module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ffa_pkg::ffa_req_t in_req_i,
  output logic              in_stall_o,
  output logic              rsp_valid_o,
  output ffa_pkg::ffa_rsp_t rsp_o,
  input  logic              rsp_ready_i,
  output ffa_pkg::hdr_req_t hreq_o,
  input  ffa_pkg::hdr_rsp_t hrsp_i
);
  import ffa_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_A_NEXT   = 11'b00000000010,
    S_A_CHECK  = 11'b00000000100,
    S_A_SPLIT  = 11'b00000001000,
    S_A_REWALK = 11'b00000010000,
    S_L_START  = 11'b00000100000,
    S_L_WALK   = 11'b00001000000,
    S_L_RDBP   = 11'b00010000000,
    S_L_RDN    = 11'b00100000000,
    S_L_MERGEP = 11'b01000000000,
    S_RESP     = 11'b10000000000
  } state_e;

  state_e         state_q, state_d;
  addr_t          rover_q, rover_d;
  addr_t          brk_q, brk_d;
  size_t          need_q, need_d;
  addr_t          prev_q, prev_d;
  addr_t          p_q, p_d;
  logic [GW-1:0]  guard_q, guard_d;
  addr_t          bp_q, bp_d;
  addr_t          lp_q, lp_d;
  addr_t          n_q, n_d;
  logic [LGW-1:0] lguard_q, lguard_d;
  size_t          bps_q, bps_d;
  addr_t          bpn_q, bpn_d;
  logic           grow_ctx_q, grow_ctx_d;
  ffa_rsp_t       res_q, res_d;

  logic [NBW:0]   nb_sum;
  size_t          need_in;
  size_t          nu;
  size_t          rem;
  logic           free_ok;
  logic           grow_fail;
  logic           found;
  logic           next_touch;
  logic           prev_touch;

  // Round the byte count up to units and add the header unit
  assign nb_sum  = {1'b0, in_req_i.nbytes} + (NBW+1)'(UNIT_BYTES - 1);
  assign need_in = SW'(nb_sum / UNIT_BYTES) + SW'(1);

  assign free_ok = (in_req_i.block_addr >= addr_t'(2)) &&
                   ((in_req_i.block_addr - addr_t'(1)) < brk_q);

  // Growth amount and arena-full test
  assign nu        = (need_q < size_t'(GROW_UNITS)) ? size_t'(GROW_UNITS) : need_q;
  assign grow_fail = (brk_q > addr_t'(DEPTH)) ||
                     ({1'b0, nu} > ((AW+1)'(DEPTH) - {1'b0, brk_q}));
  assign rem       = hrsp_i.rd_size - need_q;

  // Address-order slot test and neighbor adjacency
  assign found = ((bp_q > lp_q) && (bp_q < hrsp_i.rd_next)) ||
                 ((lp_q >= hrsp_i.rd_next) && ((bp_q > lp_q) || (bp_q < hrsp_i.rd_next)));
  assign next_touch = (({1'b0, bp_q} + {1'b0, hrsp_i.rd_size}) == {1'b0, n_q});
  assign prev_touch = (({1'b0, lp_q} + {1'b0, hrsp_i.rd_size}) == {1'b0, bp_q});

  assign in_stall_o  = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = res_q;

  // Sequence one request through the header store
  always_comb begin
    state_d    = state_q;
    rover_d    = rover_q;
    brk_d      = brk_q;
    need_d     = need_q;
    prev_d     = prev_q;
    p_d        = p_q;
    guard_d    = guard_q;
    bp_d       = bp_q;
    lp_d       = lp_q;
    n_d        = n_q;
    lguard_d   = lguard_q;
    bps_d      = bps_q;
    bpn_d      = bpn_q;
    grow_ctx_d = grow_ctx_q;
    res_d      = res_q;
    hreq_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.cmd == CMD_ALLOC) begin
            need_d         = need_in;
            prev_d         = rover_q;
            guard_d        = '0;
            hreq_o.rd_en   = 1'b1;
            hreq_o.rd_addr = rover_q;
            state_d        = S_A_NEXT;
          end else begin
            grow_ctx_d      = 1'b0;
            res_d.status    = ST_DONE;
            res_d.user_addr = '0;
            if (free_ok) begin
              bp_d    = in_req_i.block_addr - addr_t'(1);
              state_d = S_L_START;
            end else begin
              state_d = S_RESP;
            end
          end
        end
      end

      S_A_NEXT: begin
        p_d            = hrsp_i.rd_next;
        hreq_o.rd_en   = 1'b1;
        hreq_o.rd_addr = hrsp_i.rd_next;
        state_d        = S_A_CHECK;
      end

      S_A_CHECK: begin
        if (guard_q > GW'(WALK_MAX)) begin
          res_d.status    = ST_NOMEM;
          res_d.user_addr = '0;
          state_d         = S_RESP;
        end else if (hrsp_i.rd_size >= need_q) begin
          rover_d         = prev_q;
          res_d.status    = ST_DONE;
          res_d.user_addr = p_q + addr_t'(1);
          if (hrsp_i.rd_size == need_q) begin
            // exact fit: unlink the block
            hreq_o.wr_addr    = prev_q;
            hreq_o.wr_next_en = 1'b1;
            hreq_o.wr_next    = hrsp_i.rd_next;
            state_d           = S_RESP;
          end else begin
            // shrink the block and carve the tail
            hreq_o.wr_addr    = p_q;
            hreq_o.wr_size_en = 1'b1;
            hreq_o.wr_size    = rem;
            p_d               = p_q + rem;
            state_d           = S_A_SPLIT;
          end
        end else if (p_q == rover_q) begin
          if (grow_fail) begin
            res_d.status    = ST_NOMEM;
            res_d.user_addr = '0;
            state_d         = S_RESP;
          end else begin
            hreq_o.wr_addr    = brk_q;
            hreq_o.wr_size_en = 1'b1;
            hreq_o.wr_size    = nu;
            bp_d              = brk_q;
            brk_d             = brk_q + nu;
            grow_ctx_d        = 1'b1;
            state_d           = S_L_START;
          end
        end else begin
          prev_d         = p_q;
          p_d            = hrsp_i.rd_next;
          hreq_o.rd_en   = 1'b1;
          hreq_o.rd_addr = hrsp_i.rd_next;
          guard_d        = guard_q + GW'(1);
        end
      end

      S_A_SPLIT: begin
        hreq_o.wr_addr    = p_q;
        hreq_o.wr_size_en = 1'b1;
        hreq_o.wr_size    = need_q;
        res_d.user_addr   = p_q + addr_t'(1);
        state_d           = S_RESP;
      end

      S_A_REWALK: begin
        prev_d         = rover_q;
        hreq_o.rd_en   = 1'b1;
        hreq_o.rd_addr = rover_q;
        guard_d        = guard_q + GW'(1);
        state_d        = S_A_NEXT;
      end

      S_L_START: begin
        lp_d           = rover_q;
        lguard_d       = '0;
        hreq_o.rd_en   = 1'b1;
        hreq_o.rd_addr = rover_q;
        state_d        = S_L_WALK;
      end

      S_L_WALK: begin
        if (lguard_q > LGW'(LINK_MAX)) begin
          state_d = grow_ctx_q ? S_A_REWALK : S_RESP;
        end else if (found) begin
          n_d            = hrsp_i.rd_next;
          hreq_o.rd_en   = 1'b1;
          hreq_o.rd_addr = bp_q;
          state_d        = S_L_RDBP;
        end else begin
          lp_d           = hrsp_i.rd_next;
          hreq_o.rd_en   = 1'b1;
          hreq_o.rd_addr = hrsp_i.rd_next;
          lguard_d       = lguard_q + LGW'(1);
        end
      end

      S_L_RDBP: begin
        bps_d = hrsp_i.rd_size;
        if (next_touch) begin
          hreq_o.rd_en   = 1'b1;
          hreq_o.rd_addr = n_q;
          state_d        = S_L_RDN;
        end else begin
          bpn_d             = n_q;
          hreq_o.wr_addr    = bp_q;
          hreq_o.wr_next_en = 1'b1;
          hreq_o.wr_next    = n_q;
          hreq_o.rd_en      = 1'b1;
          hreq_o.rd_addr    = lp_q;
          state_d           = S_L_MERGEP;
        end
      end

      S_L_RDN: begin
        // absorb the following free block
        bps_d             = bps_q + hrsp_i.rd_size;
        bpn_d             = hrsp_i.rd_next;
        hreq_o.wr_addr    = bp_q;
        hreq_o.wr_size_en = 1'b1;
        hreq_o.wr_size    = bps_q + hrsp_i.rd_size;
        hreq_o.wr_next_en = 1'b1;
        hreq_o.wr_next    = hrsp_i.rd_next;
        hreq_o.rd_en      = 1'b1;
        hreq_o.rd_addr    = lp_q;
        state_d           = S_L_MERGEP;
      end

      S_L_MERGEP: begin
        hreq_o.wr_addr    = lp_q;
        hreq_o.wr_next_en = 1'b1;
        if (prev_touch) begin
          hreq_o.wr_size_en = 1'b1;
          hreq_o.wr_size    = hrsp_i.rd_size + bps_q;
          hreq_o.wr_next    = bpn_q;
        end else begin
          hreq_o.wr_next = bp_q;
        end
        state_d = grow_ctx_q ? S_A_REWALK : S_RESP;
      end

      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rover_q    <= '0;
      brk_q      <= addr_t'(1);
      guard_q    <= '0;
      lguard_q   <= '0;
      grow_ctx_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rover_q    <= rover_d;
      brk_q      <= brk_d;
      guard_q    <= guard_d;
      lguard_q   <= lguard_d;
      grow_ctx_q <= grow_ctx_d;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk_i) begin
    need_q <= need_d;
    prev_q <= prev_d;
    p_q    <= p_d;
    bp_q   <= bp_d;
    lp_q   <= lp_d;
    n_q    <= n_d;
    bps_q  <= bps_d;
    bpn_q  <= bpn_d;
    res_q  <= res_d;
  end

  `FFA_ASSERT(a_rover_hold, (state_q != S_A_CHECK) |=> $stable(rover_q), "rover moved outside a grant")
  `FFA_ASSERT(a_brk_mono, 1'b1 |=> ((brk_q >= $past(brk_q)) && (brk_q <= addr_t'(DEPTH))), "heap break shrank or overran the arena")
  `FFA_ASSERT(a_walk_bound, guard_q <= GW'(WALK_MAX + 1), "allocate walk counter past its bound")

endmodule

// ===== hdl/first_fit_free_list_allocator.sv =====
// Next-fit free-list allocator over a 4097-entry header arena. One request is
// taken at a time; in_stall_o is high from acceptance until the response has
// been moved into the output register, which then waits for the consumer while
// the next request is already accepted. An allocate walks the free list one block
// per header read, a split adds a second size write, and each break growth
// adds a coalescing walk before the allocate walk restarts. A free makes one
// address-ordered walk over the free list and then merges with its neighbours.
// Every list hop is one registered read of the next-pointer array, so the walk
// length sets the latency. No clearing pass is needed after reset.
`include "first_fit_free_list_allocator_macros.svh"

module first_fit_free_list_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffa_pkg::ffa_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ffa_pkg::ffa_rsp_t out_rsp_o
);
  import ffa_pkg::*;

  hdr_req_t hreq;
  hdr_rsp_t hrsp;
  logic     rsp_valid;
  logic     rsp_ready;
  ffa_rsp_t rsp;

  logic     out_vld_q, out_vld_d;
  ffa_rsp_t out_rsp_q, out_rsp_d;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_ready_i (rsp_ready),
    .hreq_o      (hreq),
    .hrsp_i      (hrsp)
  );

  ffa_hdr_store u_hdr_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  // Load the output register when empty or being drained
  assign rsp_ready = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    out_rsp_d = out_rsp_q;
    if (rsp_valid && rsp_ready) begin
      out_vld_d = 1'b1;
      out_rsp_d = rsp;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  `FFA_ASSERT(a_rsp_taken, (rsp_valid && rsp_ready) |=> out_valid_o, "response lost at output register")

endmodule
